[rtl/lrpa_pkg.sv]
//------------------------------------------------------------------------------
// lrpa_pkg: shared types and codes for the leased resource pool allocator
// Command, event and client status codes, and the cell control struct.
//------------------------------------------------------------------------------
package lrpa_pkg;

	localparam int MAX_CLIENTS = 16;
	localparam int LEASE_UNIT  = 5;
	// lease / LEASE_UNIT as (lease * LEASE_RECIP) >> LEASE_SHIFT, exact for 11-bit leases
	localparam int LEASE_SHIFT = 13;
	localparam int LEASE_RECIP = ((1 << LEASE_SHIFT) + LEASE_UNIT - 1) / LEASE_UNIT;

	typedef enum logic [1:0] {
		CMD_TAKE = 2'd0,
		CMD_GIVE = 2'd1,
		CMD_TICK = 2'd2,
		CMD_NONE = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		EV_GRANTED  = 3'd0,
		EV_BLOCKED  = 3'd1,
		EV_IGNORED  = 3'd2,
		EV_BUSY     = 3'd3,
		EV_RETURNED = 3'd4,
		EV_WOKEN    = 3'd5,
		EV_REVOKED  = 3'd6,
		EV_TICKDONE = 3'd7
	} event_t;

	typedef enum logic [1:0] {
		ST_IDLE    = 2'd0,
		ST_ACTIVE  = 2'd1,
		ST_WAITING = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_TICK,
		S_SCAN,
		S_EMIT,
		S_DONE
	} fsm_t;

	// commands from the sequencer to the row of client cells
	typedef struct packed {
		logic       sel_wr;    // write held/lease/status of selected client
		logic [7:0] held_wr;
		logic [7:0] lease_wr;
		status_t    st_wr;
		logic       shift;     // rotate tick token one cell
		logic       tick_dec;  // decrement lease of the cell holding the token
		logic       tok_load;  // place token at cell 0
	} cell_ctl_t;

endpackage

[rtl/lrpa_cell.sv]
//------------------------------------------------------------------------------
// lrpa_cell: one client entry
// Holds held count, lease and status; passes the tick token to its neighbor.
//------------------------------------------------------------------------------
module lrpa_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  lrpa_pkg::cell_ctl_t ctl,
	input  logic                sel,
	input  logic                tok_in,
	output logic                tok_q,
	output logic [7:0]          held_q,
	output logic [7:0]          lease_q,
	output lrpa_pkg::status_t   st_q
);
	import lrpa_pkg::*;

	logic expire;
	assign expire = tok_q && ctl.tick_dec && st_q == ST_ACTIVE && lease_q == 8'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q   <= 1'b0;
			held_q  <= '0;
			lease_q <= '0;
			st_q    <= ST_IDLE;
		end else begin
			if (ctl.tok_load) tok_q <= sel;
			else if (ctl.shift) tok_q <= tok_in;
			if (sel && ctl.sel_wr) begin
				held_q  <= ctl.held_wr;
				lease_q <= ctl.lease_wr;
				st_q    <= ctl.st_wr;
			end else if (tok_q && ctl.tick_dec && st_q == ST_ACTIVE && lease_q != 8'd0) begin
				lease_q <= lease_q - 8'd1;
				if (expire) begin
					held_q <= '0;
					st_q   <= ST_IDLE;
				end
			end
		end
	end
endmodule

[rtl/leased_resource_pool_allocator_core.sv]
//------------------------------------------------------------------------------
// leased_resource_pool_allocator_core: counting semaphore with leased holdings
// Client state lives in a row of cells; a sequencer walks them and the queue.
//------------------------------------------------------------------------------
// channel | direction | handshake           | payload
// in      | input     | in_valid/in_stall   | cmd client count lease_ticks
// out     | output    | out_valid/out_stall | event_res who amount free_now last
// cfg     | input     | cfg_valid/cfg_ready | cfg_data (pool_size)
// A successful give then scans the waiting queue. A tick walks the token through
// all MAX_CLIENTS cells, then scans the queue unless the queue is empty.
// Reset loads free count 8; a stalled result holds the sequencer in place.
//------------------------------------------------------------------------------
module leased_resource_pool_allocator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic [3:0]  client,
	input  logic [7:0]  count,
	input  logic [10:0] lease_ticks,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  event_res,
	output logic [3:0]  who,
	output logic [7:0]  amount,
	output logic [7:0]  free_now,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);
	import lrpa_pkg::*;

	localparam int CW = $clog2(MAX_CLIENTS);
	localparam int QW = $clog2(MAX_CLIENTS + 1);

	fsm_t state_q, state_d;
	cell_ctl_t ctl;
	logic [MAX_CLIENTS-1:0] sel, tok;
	logic [7:0] held [MAX_CLIENTS];
	logic [7:0] lease [MAX_CLIENTS];
	status_t st [MAX_CLIENTS];

	logic [7:0] free_q, free_d;
	logic [CW-1:0] wq_q [MAX_CLIENTS];
	logic [QW-1:0] wlen_q, wlen_d, ri_q, ri_d, wk_q, wk_d;
	logic [CW-1:0] idx_q, idx_d;
	logic [CW-1:0] cur;
	logic [QW-1:0] tcnt_q, tcnt_d;
	logic wq_we;
	logic [QW-1:0] wq_wa;
	logic [CW-1:0] wq_wd;
	logic [2:0] ev_q, ev_d;
	logic [3:0] who_q, who_d;
	logic [7:0] amt_q, amt_d;
	logic [7:0] fn_q, fn_d;
	logic last_q, last_d, ov_q, ov_d;
	fsm_t ret_q, ret_d;
	logic [1:0] cmd_s1; logic [3:0] cl_s1; logic [7:0] cnt_s1; logic [10:0] ls_s1;
	logic take_s1;

	genvar g;
	generate
		for (g = 0; g < MAX_CLIENTS; g++) begin : g_cell
			lrpa_cell u_cell (
				.clk(clk), .arst_n(arst_n), .ctl(ctl), .sel(sel[g]),
				.tok_in(tok[(g + MAX_CLIENTS - 1) % MAX_CLIENTS]),
				.tok_q(tok[g]), .held_q(held[g]), .lease_q(lease[g]), .st_q(st[g])
			);
		end
	endgenerate

	always_comb begin
		for (int i = 0; i < MAX_CLIENTS; i++) sel[i] = (cur == CW'(i));
	end

	logic [21:0] prod;
	logic [10:0] per;
	logic [10:0] rem;
	logic [8:0] fsum;
	assign prod = {11'd0, ls_s1} * 22'(LEASE_RECIP);
	assign per = 11'(prod >> LEASE_SHIFT);
	assign rem = ls_s1 - 11'(per * 11'(LEASE_UNIT));
	logic [7:0] cur_held, tok_held, tok_lease; status_t tok_st;
	logic [CW-1:0] qc;
	assign qc = wq_q[ri_q[CW-1:0]];
	assign cur_held = held[cur];
	always_comb begin
		tok_held = '0; tok_lease = '0; tok_st = ST_IDLE;
		for (int i = 0; i < MAX_CLIENTS; i++)
			if (tok[i]) begin tok_held = held[i]; tok_lease = lease[i]; tok_st = st[i]; end
	end
	assign in_stall  = (state_q != S_IDLE) || cfg_valid || ov_q;
	assign cfg_ready = (state_q == S_IDLE) && !out_valid;
	assign out_valid = ov_q;
	assign event_res = ev_q; assign who = who_q; assign amount = amt_q;
	assign free_now = fn_q; assign last = last_q;

	always_comb begin
		logic [7:0] a;
		logic more;
		logic chk_more;
		state_d = state_q; free_d = free_q; wlen_d = wlen_q; ri_d = ri_q; wk_d = wk_q;
		idx_d = idx_q; tcnt_d = tcnt_q; ev_d = ev_q; who_d = who_q; amt_d = amt_q;
		fn_d = fn_q; last_d = last_q; ov_d = ov_q && out_stall; ret_d = ret_q;
		ctl = '0; ctl.st_wr = ST_IDLE; cur = idx_q; wq_we = 1'b0;
		wq_wa = wlen_q; wq_wd = idx_q; a = '0; fsum = '0;
		take_s1 = 1'b0; more = 1'b0; chk_more = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (cfg_valid && cfg_ready) free_d = cfg_data;
				else if (in_valid && !in_stall) begin
					state_d = S_EMIT; take_s1 = 1'b1;
				end
			end
			S_EMIT: begin
				// decode the latched command
				cur = cl_s1[CW-1:0];
				ret_d = S_DONE; last_d = 1'b1; amt_d = '0; who_d = cl_s1;
				if (cmd_s1 == CMD_TICK) begin
					ctl.tok_load = 1'b1; cur = '0; tcnt_d = '0;
					state_d = S_TICK; last_d = 1'b0;
				end else if (cmd_s1 == CMD_NONE || {28'd0, cl_s1} >= 32'(MAX_CLIENTS)) begin
					ev_d = EV_IGNORED;
				end else if (cmd_s1 == CMD_TAKE) begin
					if (rem != '0) ev_d = EV_IGNORED;
					else if (st[cur] != ST_IDLE) ev_d = EV_BUSY;
					else begin
						ctl.sel_wr = 1'b1; ctl.held_wr = cnt_s1;
						ctl.lease_wr = (per > 11'd255) ? 8'd255 : per[7:0];
						if (free_q >= cnt_s1) begin
							free_d = free_q - cnt_s1; ctl.st_wr = ST_ACTIVE;
							ev_d = EV_GRANTED; amt_d = cnt_s1;
						end else begin
							ctl.st_wr = ST_WAITING; ev_d = EV_BLOCKED;
							if (wlen_q < QW'(MAX_CLIENTS)) begin
								wq_we = 1'b1; wq_wd = cur; wlen_d = wlen_q + 1'b1;
							end
						end
					end
				end else begin
					if (st[cur] != ST_ACTIVE || cur_held == 8'd0) ev_d = EV_IGNORED;
					else begin
						a = (cnt_s1 > cur_held) ? cur_held : cnt_s1;
						ctl.sel_wr = 1'b1; ctl.held_wr = cur_held - a;
						ctl.lease_wr = lease[cur]; ctl.st_wr = ST_ACTIVE;
						if (cur_held == a) begin ctl.st_wr = ST_IDLE; ctl.lease_wr = '0; end
						fsum = {1'b0, free_q} + {1'b0, a};
						free_d = fsum[8] ? 8'd255 : fsum[7:0];
						ev_d = EV_RETURNED; amt_d = a; ret_d = S_SCAN;
						ri_d = '0; wk_d = '0; last_d = 1'b0;
					end
				end
				if (cmd_s1 != CMD_TICK) begin
					fn_d = free_d; ov_d = 1'b1; state_d = ret_d;
					if (ret_d == S_SCAN) chk_more = 1'b1;
				end
			end
			S_TICK: begin
				if (!ov_q || !out_stall) begin
					if (tcnt_q == QW'(MAX_CLIENTS)) begin
						state_d = S_SCAN; ri_d = '0; wk_d = '0;
						if (wlen_q == '0) begin
							ev_d = EV_TICKDONE; who_d = '0; amt_d = '0; fn_d = free_q;
							last_d = 1'b1; ov_d = 1'b1; state_d = S_DONE;
						end
					end else begin
						ctl.tick_dec = 1'b1; ctl.shift = 1'b1; tcnt_d = tcnt_q + 1'b1;
						if (tok_st == ST_ACTIVE && tok_lease == 8'd1) begin
							fsum = {1'b0, free_q} + {1'b0, tok_held};
							free_d = fsum[8] ? 8'd255 : fsum[7:0];
							ev_d = EV_REVOKED; who_d = 4'(tcnt_q); amt_d = tok_held;
							fn_d = free_d; last_d = 1'b0; ov_d = 1'b1;
						end
					end
				end
			end
			S_SCAN: begin
				cur = qc;
				if (!ov_q || !out_stall) begin
					if (ri_q >= wlen_q) begin
						wlen_d = wk_q;
						if (cmd_s1 == CMD_TICK) begin
							ev_d = EV_TICKDONE; who_d = '0; amt_d = '0; fn_d = free_q;
							last_d = 1'b1; ov_d = 1'b1;
						end
						state_d = S_DONE;
					end else begin
						ri_d = ri_q + 1'b1;
						if (cur_held <= free_q) begin
							free_d = free_q - cur_held;
							ctl.sel_wr = 1'b1; ctl.held_wr = cur_held;
							ctl.lease_wr = lease[cur]; ctl.st_wr = ST_ACTIVE;
							ev_d = EV_WOKEN; who_d = 4'(qc); amt_d = cur_held;
							fn_d = free_d; ov_d = 1'b1; last_d = 1'b0;
							chk_more = (cmd_s1 != CMD_TICK);
						end else begin
							wq_we = 1'b1; wq_wa = wk_q; wq_wd = qc; wk_d = wk_q + 1'b1;
						end
					end
				end
			end
			S_DONE: begin
				if (!ov_q || !out_stall) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
		// a later wake follows only if some other waiting client fits what is left
		for (int i = 0; i < MAX_CLIENTS; i++)
			if (st[i] == ST_WAITING && cur != CW'(i) && held[i] <= free_d) more = 1'b1;
		if (chk_more) last_d = !more;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; free_q <= 8'd8; wlen_q <= '0; ri_q <= '0; wk_q <= '0;
			idx_q <= '0; tcnt_q <= '0; ov_q <= 1'b0; ret_q <= S_DONE;
		end else begin
			state_q <= state_d; free_q <= free_d; wlen_q <= wlen_d; ri_q <= ri_d;
			wk_q <= wk_d; idx_q <= idx_d; tcnt_q <= tcnt_d; ov_q <= ov_d; ret_q <= ret_d;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1) begin
			cmd_s1 <= cmd; cl_s1 <= client; cnt_s1 <= count; ls_s1 <= lease_ticks;
		end
		if (ov_d && !(ov_q && out_stall)) begin
			ev_q <= ev_d; who_q <= who_d; amt_q <= amt_d; fn_q <= fn_d;
		end
		last_q <= last_d;
		if (wq_we) wq_q[wq_wa[CW-1:0]] <= wq_wd;
	end
endmodule

[rtl/lrpa_checker.sv]
//------------------------------------------------------------------------------
// lrpa_checker: port-level checks for the allocator
// Watches the handshakes and result framing on the top level.
//------------------------------------------------------------------------------
module lrpa_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [2:0] event_res,
	input logic [3:0] who,
	input logic [7:0] amount,
	input logic       last,
	input logic       cfg_valid,
	input logic       cfg_ready
);
	import lrpa_pkg::*;

	// a held result keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(event_res) && $stable(amount))
		else $error("stalled result changed");

	// tick done always closes the transaction
	a_tick_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_res == EV_TICKDONE |-> last && who == 4'd0)
		else $error("tick done not last");

	// no new input is taken while configuration is written
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |-> in_stall)
		else $error("input taken during configuration write");

	// a result with no amount never claims instances
	a_amt: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_res == EV_BLOCKED || event_res == EV_IGNORED
		|| event_res == EV_BUSY) |-> amount == 8'd0)
		else $error("nonzero amount on empty event");
endmodule

bind leased_resource_pool_allocator_core lrpa_checker u_lrpa_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .event_res(event_res),
	.who(who), .amount(amount), .last(last), .cfg_valid(cfg_valid),
	.cfg_ready(cfg_ready)
);
